// ===== rtl/sbic_pkg.sv =====
// Package for the stack bytecode integer core: opcodes, status codes,
// controller command and status structs. No dependencies.
package sbic_pkg;

  localparam logic [7:0] OP_NOP     = 8'h00;
  localparam logic [7:0] OP_ICONST0 = 8'h03;
  localparam logic [7:0] OP_ICONST5 = 8'h08;
  localparam logic [7:0] OP_BIPUSH  = 8'h10;
  localparam logic [7:0] OP_SIPUSH  = 8'h11;
  localparam logic [7:0] OP_ILOAD0  = 8'h1A;
  localparam logic [7:0] OP_ILOAD3  = 8'h1D;
  localparam logic [7:0] OP_ISTORE  = 8'h36;
  localparam logic [7:0] OP_ISTORE0 = 8'h3B;
  localparam logic [7:0] OP_ISTORE3 = 8'h3E;
  localparam logic [7:0] OP_DUP     = 8'h59;
  localparam logic [7:0] OP_IADD    = 8'h60;
  localparam logic [7:0] OP_ISUB    = 8'h64;
  localparam logic [7:0] OP_IMUL    = 8'h68;
  localparam logic [7:0] OP_IDIV    = 8'h6C;
  localparam logic [7:0] OP_IINC    = 8'h84;
  localparam logic [7:0] OP_IFCMPNE = 8'hA0;
  localparam logic [7:0] OP_IFCMPLT = 8'hA1;
  localparam logic [7:0] OP_IFCMPGE = 8'hA2;
  localparam logic [7:0] OP_IFCMPGT = 8'hA3;
  localparam logic [7:0] OP_IFCMPLE = 8'hA4;
  localparam logic [7:0] OP_GOTO    = 8'hA7;
  localparam logic [7:0] OP_IRETURN = 8'hAC;
  localparam logic [7:0] OP_RETURN  = 8'hB1;

  localparam logic [2:0] ST_RUN   = 3'd0;
  localparam logic [2:0] ST_IRET  = 3'd1;
  localparam logic [2:0] ST_RET   = 3'd2;
  localparam logic [2:0] ST_BADOP = 3'd3;
  localparam logic [2:0] ST_STACK = 3'd4;
  localparam logic [2:0] ST_DIV0  = 3'd5;

  localparam logic [15:0] LEN_TWO   = 16'd2;
  localparam logic [15:0] LEN_THREE = 16'd3;

  typedef struct packed {
    logic [7:0] opcode;
    logic [7:0] operand_hi;
    logic [7:0] operand_lo;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [2:0]  status;
    logic [31:0] value;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic   load;      // capture instruction, read stack operands
    logic   exec;      // evaluate and commit (non-divide)
    logic   div_start; // start the divider
    logic   div_done;  // commit division result
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_div; // loaded instruction is a valid idiv with nonzero divisor
    logic div_busy;
  } dp_stat_t;

endpackage

// ===== rtl/sbic_if.sv =====
// Valid/ready channel interface for the stack bytecode integer core.
// Payload type is a parameter; no package dependency.
interface sbic_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/sbic_div.sv =====
// Iterative 32-bit signed divider, one quotient bit per cycle.
// Depends on nothing.
module sbic_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        busy_o,
  output logic [31:0] q_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [32:0] trial;

  // Restoring division on magnitudes.
  always_comb begin
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    neg_d = neg_q; busy_d = busy_q;
    trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = a_i[31] ? 32'(-a_i) : a_i;
      dvs_d  = b_i[31] ? 32'(-b_i) : b_i;
      neg_d  = a_i[31] ^ b_i[31];
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) rem_d = trial[31:0];
      else rem_d = {rem_q[30:0], quo_q[31]};
      quo_d = {quo_q[30:0], !trial[32]};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d; neg_q <= neg_d;
  end

  assign busy_o = busy_q;
  assign q_o    = neg_q ? 32'(-quo_q) : quo_q;
endmodule

// ===== rtl/sbic_datapath.sv =====
// Datapath: program counter, locals, operand stack, arithmetic and result.
// Depends on sbic_pkg and sbic_div.
module sbic_datapath #(
  parameter int LOCAL_COUNT = 256,
  parameter int STACK_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sbic_pkg::instr_t    instr_i,
  input  sbic_pkg::dp_cmd_t   cmd_i,
  output sbic_pkg::dp_stat_t  stat_o,
  output sbic_pkg::result_t   result_o
);
  localparam int LW = (LOCAL_COUNT > 1) ? $clog2(LOCAL_COUNT) : 1;
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);

  // Locals: memory plus a valid bit per entry, reading zero until written.
  logic [31:0]            locals_mem [LOCAL_COUNT];
  logic [LOCAL_COUNT-1:0] lvalid_q;
  logic [31:0]            stack_mem  [STACK_DEPTH];

  sbic_pkg::instr_t ir_q;
  logic [15:0] pc_q, pc_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [2:0]  halt_q, halt_d;
  logic [31:0] top_q, sec_q, loc_q;
  logic        lval_q;
  sbic_pkg::result_t res_q, res_d;

  logic [7:0]  op, b1, b2;
  logic [15:0] off16;
  logic [31:0] loc_rd, top_v, sec_v, push_v, arith_v, div_q;
  logic        do_push, do_pop1, do_ar, do_lst, do_linc, take;
  logic [2:0]  st;
  logic [LW-1:0] lidx;
  logic [8:0]  lidx_full;
  logic        div_busy;

  assign op = ir_q.opcode;
  assign b1 = ir_q.operand_hi;
  assign b2 = ir_q.operand_lo;
  assign off16 = {b1, b2};
  assign loc_rd = lval_q ? loc_q : 32'd0;

  // Local index of the captured instruction.
  always_comb begin
    lidx_full = {1'b0, instr_i.operand_hi};
    if (instr_i.opcode >= sbic_pkg::OP_ILOAD0 && instr_i.opcode <= sbic_pkg::OP_ILOAD3)
      lidx_full = 9'(instr_i.opcode - sbic_pkg::OP_ILOAD0);
    else if (instr_i.opcode >= sbic_pkg::OP_ISTORE0 && instr_i.opcode <= sbic_pkg::OP_ISTORE3)
      lidx_full = 9'(instr_i.opcode - sbic_pkg::OP_ISTORE0);
  end

  logic [LW-1:0] rd_lidx;
  assign rd_lidx = LW'(lidx_full);
  assign lidx    = (op == sbic_pkg::OP_ISTORE || op == sbic_pkg::OP_IINC) ? LW'(b1) :
                   (op >= sbic_pkg::OP_ISTORE0 && op <= sbic_pkg::OP_ISTORE3) ?
                   LW'(op - sbic_pkg::OP_ISTORE0) : LW'(0);

  // Load cycle: capture instruction, read top two stack entries and a local.
  logic [SW-1:0] ra1, ra2;
  assign ra1 = SW'(depth_q - DW'(1));
  assign ra2 = SW'(depth_q - DW'(2));
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ir_q   <= instr_i;
      top_q  <= stack_mem[ra1];
      sec_q  <= stack_mem[ra2];
      loc_q  <= locals_mem[rd_lidx];
      lval_q <= lvalid_q[rd_lidx];
    end
  end
  assign top_v = top_q;
  assign sec_v = sec_q;

  // Decode and evaluate in the execute cycle.
  always_comb begin
    logic bad_idx;
    bad_idx = (32'(b1) >= 32'(LOCAL_COUNT));
    pc_d = pc_q; depth_d = depth_q; halt_d = halt_q;
    st = sbic_pkg::ST_RUN; push_v = '0; arith_v = '0;
    do_push = 1'b0; do_pop1 = 1'b0; do_ar = 1'b0; do_lst = 1'b0; do_linc = 1'b0;
    take = 1'b0;
    res_d = '0;
    if (halt_q != sbic_pkg::ST_RUN) begin
      res_d.next_pc = pc_q; res_d.status = halt_q;
    end else begin
      res_d.next_pc = pc_q;
      if (op >= sbic_pkg::OP_ICONST0 && op <= sbic_pkg::OP_ICONST5 ||
          op == sbic_pkg::OP_BIPUSH || op == sbic_pkg::OP_SIPUSH ||
          op >= sbic_pkg::OP_ILOAD0 && op <= sbic_pkg::OP_ILOAD3) begin
        if (32'(depth_q) >= 32'(STACK_DEPTH)) st = sbic_pkg::ST_STACK;
        else begin
          do_push = 1'b1;
          if (op == sbic_pkg::OP_BIPUSH) begin
            push_v = {{24{b1[7]}}, b1}; pc_d = pc_q + sbic_pkg::LEN_TWO;
          end else if (op == sbic_pkg::OP_SIPUSH) begin
            push_v = {{16{b1[7]}}, off16}; pc_d = pc_q + sbic_pkg::LEN_THREE;
          end else if (op <= sbic_pkg::OP_ICONST5) begin
            push_v = 32'(op - sbic_pkg::OP_ICONST0); pc_d = pc_q + 16'd1;
          end else begin
            push_v = loc_rd; pc_d = pc_q + 16'd1;
          end
        end
      end else if (op == sbic_pkg::OP_ISTORE ||
                   op >= sbic_pkg::OP_ISTORE0 && op <= sbic_pkg::OP_ISTORE3) begin
        if (op == sbic_pkg::OP_ISTORE && bad_idx) st = sbic_pkg::ST_BADOP;
        else if (depth_q == '0) st = sbic_pkg::ST_STACK;
        else begin
          do_lst = 1'b1; do_pop1 = 1'b1;
          pc_d = pc_q + ((op == sbic_pkg::OP_ISTORE) ? sbic_pkg::LEN_TWO : 16'd1);
        end
      end else if (op == sbic_pkg::OP_IADD || op == sbic_pkg::OP_ISUB ||
                   op == sbic_pkg::OP_IMUL || op == sbic_pkg::OP_IDIV) begin
        if (depth_q < DW'(2)) st = sbic_pkg::ST_STACK;
        else if (op == sbic_pkg::OP_IDIV && top_v == '0) st = sbic_pkg::ST_DIV0;
        else begin
          do_ar = 1'b1; pc_d = pc_q + 16'd1;
          unique case (op)
            sbic_pkg::OP_IADD: arith_v = sec_v + top_v;
            sbic_pkg::OP_ISUB: arith_v = sec_v - top_v;
            sbic_pkg::OP_IMUL: arith_v = 32'(sec_v * top_v);
            default:           arith_v = div_q;
          endcase
        end
      end else if (op == sbic_pkg::OP_DUP) begin
        if (depth_q == '0 || 32'(depth_q) >= 32'(STACK_DEPTH)) st = sbic_pkg::ST_STACK;
        else begin
          do_push = 1'b1; push_v = top_v; pc_d = pc_q + 16'd1;
        end
      end else if (op == sbic_pkg::OP_IINC) begin
        if (bad_idx) st = sbic_pkg::ST_BADOP;
        else begin
          do_linc = 1'b1; pc_d = pc_q + sbic_pkg::LEN_THREE;
        end
      end else if (op == sbic_pkg::OP_GOTO) begin
        pc_d = pc_q + off16;
      end else if (op >= sbic_pkg::OP_IFCMPNE && op <= sbic_pkg::OP_IFCMPLE) begin
        if (depth_q < DW'(2)) st = sbic_pkg::ST_STACK;
        else begin
          unique case (op)
            sbic_pkg::OP_IFCMPNE: take = sec_v != top_v;
            sbic_pkg::OP_IFCMPLT: take = $signed(sec_v) <  $signed(top_v);
            sbic_pkg::OP_IFCMPGE: take = $signed(sec_v) >= $signed(top_v);
            sbic_pkg::OP_IFCMPGT: take = $signed(sec_v) >  $signed(top_v);
            default:              take = $signed(sec_v) <= $signed(top_v);
          endcase
          depth_d = depth_q - DW'(2);
          pc_d = take ? pc_q + off16 : pc_q + sbic_pkg::LEN_THREE;
        end
      end else if (op == sbic_pkg::OP_IRETURN) begin
        if (depth_q == '0) st = sbic_pkg::ST_STACK;
        else begin
          st = sbic_pkg::ST_IRET; res_d.value = top_v; depth_d = depth_q - DW'(1);
        end
      end else if (op == sbic_pkg::OP_RETURN) begin
        st = sbic_pkg::ST_RET;
        if (depth_q != '0) res_d.value = top_v;
      end else if (op == sbic_pkg::OP_NOP) begin
        pc_d = pc_q + 16'd1;
      end else begin
        st = sbic_pkg::ST_BADOP;
      end
      if (do_push) depth_d = depth_q + DW'(1);
      if (do_pop1 || do_ar) depth_d = depth_q - DW'(1);
      halt_d = st;
      res_d.next_pc = pc_d;
      res_d.status = st;
    end
  end

  logic commit;
  assign commit = cmd_i.exec || cmd_i.div_done;

  // Architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; depth_q <= '0; halt_q <= sbic_pkg::ST_RUN; lvalid_q <= '0;
    end else if (commit) begin
      pc_q <= pc_d; depth_q <= depth_d; halt_q <= halt_d;
      if (halt_q == sbic_pkg::ST_RUN && (do_lst || do_linc)) lvalid_q[lidx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && halt_q == sbic_pkg::ST_RUN) begin
      if (do_push) stack_mem[SW'(depth_q)] <= push_v;
      if (do_ar)   stack_mem[ra2] <= arith_v;
      if (do_lst)  locals_mem[lidx] <= top_v;
      if (do_linc) locals_mem[lidx] <= loc_rd + {{24{b2[7]}}, b2};
    end
    if (commit) res_q <= res_d;
  end

  sbic_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .a_i     (sec_q),
    .b_i     (top_q),
    .busy_o  (div_busy),
    .q_o     (div_q)
  );

  assign stat_o.need_div = (halt_q == sbic_pkg::ST_RUN) && (op == sbic_pkg::OP_IDIV) &&
                           (depth_q >= DW'(2)) && (top_v != '0);
  assign stat_o.div_busy = div_busy;
  assign result_o = res_q;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(depth_q) <= 32'(STACK_DEPTH)) else $error("stack depth beyond capacity");
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q != sbic_pkg::ST_RUN |=> $stable(halt_q) && $stable(pc_q))
    else $error("halted state changed");
  a_no_cmd_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.exec && cmd_i.div_done)) else $error("double commit");
`endif
endmodule

// ===== rtl/sbic_ctrl.sv =====
// Controller state machine sequencing fetch, execute, divide and output.
// Depends on sbic_pkg.
module sbic_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sbic_pkg::dp_cmd_t  cmd_o,
  input  sbic_pkg::dp_stat_t stat_i
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_DIVS = 5'b00100,
    S_DIVW = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Output register: a waiting result holds off the next load until it is taken.
  logic ovalid_q, ovalid_d;
  logic accept;

  assign in_ready_o = (state_q == S_IDLE) && (!ovalid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ovalid_d = ovalid_q;
    cmd_o = '0;
    if (ovalid_q && out_ready_i) ovalid_d = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = accept;
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.need_div) state_d = S_DIVS;
        else begin
          cmd_o.exec = 1'b1;
          state_d = S_OUT;
        end
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (!stat_i.div_busy) begin
          cmd_o.div_done = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        ovalid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC) else $error("accept did not start execute");
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT |-> !ovalid_q || out_ready_i) else $error("result overwritten");
`endif
endmodule

// ===== rtl/stack_bytecode_integer_core.sv =====
// Stack bytecode integer core: executes one integer bytecode per input beat.
// An instruction passes the accept, execute and output states of the
// controller; idiv adds a divider start, 32 quotient steps and a commit.
// A new instruction is accepted only in the idle state, once the previous
// result sits in the output register and that register is free or being taken.
// Reset (async, active low) zeroes the program counter, stack depth and
// status; locals read as zero via per-entry valid bits, no clearing pass.
module stack_bytecode_integer_core #(
  parameter int LOCAL_COUNT = 256,
  parameter int STACK_DEPTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  sbic_if.sink   in_i,
  sbic_if.source out_o
);
  sbic_pkg::dp_cmd_t  cmd;
  sbic_pkg::dp_stat_t stat;
  sbic_pkg::result_t  res;

  sbic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  sbic_datapath #(
    .LOCAL_COUNT (LOCAL_COUNT),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .instr_i  (in_i.data),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (res)
  );

  assign out_o.data = res;
endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the stack bytecode integer core.
// Depends on sbic_pkg and sbic_if. Drives bytecode beats, predicts every result.
`timescale 1ns / 1ps

module tb_top;

  localparam int NLOC = 256;
  localparam int NSTK = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  sbic_if #(.T(sbic_pkg::instr_t))  in_if ();
  sbic_if #(.T(sbic_pkg::result_t)) out_if ();

  stack_bytecode_integer_core #(.LOCAL_COUNT(NLOC), .STACK_DEPTH(NSTK)) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Interpreter state mirrored by the predictor.
  logic [15:0] pc_q;
  logic [31:0] locals_q [NLOC];
  logic [31:0] stack_q [NSTK];
  int          depth_q;
  logic [2:0]  halt_q;

  sbic_pkg::result_t pending_results [$];
  int          errors = 0;
  int          beats_sent = 0;
  int          beats_seen = 0;
  int          halts_seen = 0;
  bit          hold_sink = 1'b0;
  bit          calm = 1'b0;

  function automatic void reset_model();
    pc_q = '0;
    foreach (locals_q[i]) locals_q[i] = '0;
    depth_q = 0;
    halt_q = sbic_pkg::ST_RUN;
  endfunction

  function automatic logic [31:0] divide_trunc(logic [31:0] a, logic [31:0] b);
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q = ma / mb;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  // Executes one instruction on the mirrored state and returns its result.
  function automatic sbic_pkg::result_t execute_instr(sbic_pkg::instr_t ins);
    sbic_pkg::result_t r;
    logic [15:0] off;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] x;
    logic [31:0] y;
    bit          take;
    r.next_pc = pc_q;
    r.status = sbic_pkg::ST_RUN;
    r.value = '0;
    off = {ins.operand_hi, ins.operand_lo};
    if (halt_q != sbic_pkg::ST_RUN) begin
      r.status = halt_q;
      return r;
    end
    case (ins.opcode) inside
      [sbic_pkg::OP_ICONST0:sbic_pkg::OP_ICONST5], sbic_pkg::OP_BIPUSH,
      sbic_pkg::OP_SIPUSH, [sbic_pkg::OP_ILOAD0:sbic_pkg::OP_ILOAD3]: begin
        if (depth_q >= NSTK) r.status = sbic_pkg::ST_STACK;
        else begin
          if (ins.opcode == sbic_pkg::OP_BIPUSH) begin
            stack_q[depth_q] = {{24{ins.operand_hi[7]}}, ins.operand_hi};
            r.next_pc = pc_q + sbic_pkg::LEN_TWO;
          end else if (ins.opcode == sbic_pkg::OP_SIPUSH) begin
            stack_q[depth_q] = {{16{off[15]}}, off};
            r.next_pc = pc_q + sbic_pkg::LEN_THREE;
          end else if (ins.opcode <= sbic_pkg::OP_ICONST5) begin
            stack_q[depth_q] = 32'(ins.opcode - sbic_pkg::OP_ICONST0);
            r.next_pc = pc_q + 16'd1;
          end else begin
            stack_q[depth_q] = locals_q[ins.opcode - sbic_pkg::OP_ILOAD0];
            r.next_pc = pc_q + 16'd1;
          end
          depth_q++;
        end
      end
      sbic_pkg::OP_ISTORE, [sbic_pkg::OP_ISTORE0:sbic_pkg::OP_ISTORE3]: begin
        if (depth_q == 0) r.status = sbic_pkg::ST_STACK;
        else begin
          depth_q--;
          if (ins.opcode == sbic_pkg::OP_ISTORE) begin
            locals_q[ins.operand_hi] = stack_q[depth_q];
            r.next_pc = pc_q + sbic_pkg::LEN_TWO;
          end else begin
            locals_q[ins.opcode - sbic_pkg::OP_ISTORE0] = stack_q[depth_q];
            r.next_pc = pc_q + 16'd1;
          end
        end
      end
      sbic_pkg::OP_IADD, sbic_pkg::OP_ISUB, sbic_pkg::OP_IMUL, sbic_pkg::OP_IDIV: begin
        if (depth_q < 2) r.status = sbic_pkg::ST_STACK;
        else begin
          b = stack_q[depth_q - 1];
          a = stack_q[depth_q - 2];
          if (ins.opcode == sbic_pkg::OP_IDIV && b == 0) r.status = sbic_pkg::ST_DIV0;
          else begin
            case (ins.opcode)
              sbic_pkg::OP_IADD: x = a + b;
              sbic_pkg::OP_ISUB: x = a - b;
              sbic_pkg::OP_IMUL: x = a * b;
              default:           x = divide_trunc(a, b);
            endcase
            depth_q--;
            stack_q[depth_q - 1] = x;
            r.next_pc = pc_q + 16'd1;
          end
        end
      end
      sbic_pkg::OP_DUP: begin
        if (depth_q == 0 || depth_q >= NSTK) r.status = sbic_pkg::ST_STACK;
        else begin
          stack_q[depth_q] = stack_q[depth_q - 1];
          depth_q++;
          r.next_pc = pc_q + 16'd1;
        end
      end
      sbic_pkg::OP_IINC: begin
        locals_q[ins.operand_hi] += {{24{ins.operand_lo[7]}}, ins.operand_lo};
        r.next_pc = pc_q + sbic_pkg::LEN_THREE;
      end
      sbic_pkg::OP_GOTO: r.next_pc = pc_q + off;
      [sbic_pkg::OP_IFCMPNE:sbic_pkg::OP_IFCMPLE]: begin
        if (depth_q < 2) r.status = sbic_pkg::ST_STACK;
        else begin
          y = stack_q[depth_q - 1];
          x = stack_q[depth_q - 2];
          depth_q -= 2;
          case (ins.opcode)
            sbic_pkg::OP_IFCMPNE: take = x != y;
            sbic_pkg::OP_IFCMPLT: take = $signed(x) < $signed(y);
            sbic_pkg::OP_IFCMPGE: take = $signed(x) >= $signed(y);
            sbic_pkg::OP_IFCMPGT: take = $signed(x) > $signed(y);
            default:              take = $signed(x) <= $signed(y);
          endcase
          r.next_pc = take ? pc_q + off : pc_q + sbic_pkg::LEN_THREE;
        end
      end
      sbic_pkg::OP_IRETURN: begin
        if (depth_q == 0) r.status = sbic_pkg::ST_STACK;
        else begin
          depth_q--;
          r.value = stack_q[depth_q];
          r.status = sbic_pkg::ST_IRET;
        end
      end
      sbic_pkg::OP_RETURN: begin
        if (depth_q != 0) r.value = stack_q[depth_q - 1];
        r.status = sbic_pkg::ST_RET;
      end
      sbic_pkg::OP_NOP: r.next_pc = pc_q + 16'd1;
      default: r.status = sbic_pkg::ST_BADOP;
    endcase
    pc_q = r.next_pc;
    halt_q = r.status;
    return r;
  endfunction

  // Sends one instruction beat; the sender idles at random unless calm.
  task automatic send_instr(sbic_pkg::instr_t ins);
    while (!calm && $urandom_range(99) < 26) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= ins;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_results.push_back(execute_instr(ins));
    beats_sent++;
  endtask

  // Restarts a program: reset is not reasserted, so a halt is left with
  // an idle gap and a fresh mirrored state is impossible; instead programs
  // run until a halt, after which the rest of the stream is ignored.
  // To keep deep coverage, a single long well-formed program is used.

  function automatic sbic_pkg::instr_t mk(logic [7:0] op, logic [7:0] hi, logic [7:0] lo);
    sbic_pkg::instr_t i;
    i.opcode = op;
    i.operand_hi = hi;
    i.operand_lo = lo;
    return i;
  endfunction

  // One random instruction that keeps the program running.
  function automatic sbic_pkg::instr_t random_running_instr();
    logic [7:0] hi;
    logic [7:0] lo;
    int         k;
    hi = 8'($urandom);
    lo = 8'($urandom);
    k = $urandom_range(15);
    if (depth_q < 2) k = $urandom_range(3);
    else if (depth_q >= NSTK - 1) k = 4 + $urandom_range(11);
    case (k)
      0: return mk(8'(sbic_pkg::OP_ICONST0 + $urandom_range(5)), hi, lo);
      1: return mk(sbic_pkg::OP_BIPUSH, hi, lo);
      2: return mk(sbic_pkg::OP_SIPUSH, hi, lo);
      3: return mk(8'(sbic_pkg::OP_ILOAD0 + $urandom_range(3)), hi, lo);
      4: return mk(sbic_pkg::OP_ISTORE, hi, lo);
      5: return mk(8'(sbic_pkg::OP_ISTORE0 + $urandom_range(3)), hi, lo);
      6: return mk(sbic_pkg::OP_IADD, hi, lo);
      7: return mk(sbic_pkg::OP_ISUB, hi, lo);
      8: return mk(sbic_pkg::OP_IMUL, hi, lo);
      9: return (stack_q[depth_q - 1] == 0) ? mk(sbic_pkg::OP_NOP, hi, lo) :
                                              mk(sbic_pkg::OP_IDIV, hi, lo);
      // A full stack cannot take another copy of the top.
      10: return (depth_q >= NSTK) ? mk(sbic_pkg::OP_NOP, hi, lo) :
                                     mk(sbic_pkg::OP_DUP, hi, lo);
      11: return mk(sbic_pkg::OP_IINC, hi, lo);
      12: return mk(sbic_pkg::OP_GOTO, hi, lo);
      13: return mk(8'(sbic_pkg::OP_IFCMPNE + $urandom_range(4)), hi, lo);
      14: return mk(sbic_pkg::OP_NOP, hi, lo);
      default: return mk(sbic_pkg::OP_IINC, 8'($urandom_range(3)), lo);
    endcase
  endfunction

  // Directed rows: the program counter starts at zero after reset.
  typedef struct {
    sbic_pkg::instr_t  ins;
    bit                known;
    sbic_pkg::result_t res;
  } row_t;

  row_t directed [$];

  function automatic void add_row(sbic_pkg::instr_t ins, bit known, logic [15:0] npc,
                                  logic [2:0] st, logic [31:0] val);
    row_t r;
    r.ins = ins;
    r.known = known;
    r.res.next_pc = npc;
    r.res.status = st;
    r.res.value = val;
    directed.push_back(r);
  endfunction

  // Stimulus.
  initial begin
    sbic_pkg::instr_t  ins;
    sbic_pkg::result_t got;
    in_if.valid = 1'b0;
    in_if.data = '0;
    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of every push form, arithmetic corners, branches both ways.
    add_row(mk(sbic_pkg::OP_NOP, 8'h00, 8'h00), 1, 16'd1, sbic_pkg::ST_RUN, 32'd0);
    add_row(mk(sbic_pkg::OP_BIPUSH, 8'h80, 8'hFF), 1, 16'd3, sbic_pkg::ST_RUN, 32'd0);
    add_row(mk(sbic_pkg::OP_SIPUSH, 8'h80, 8'h00), 1, 16'd6, sbic_pkg::ST_RUN, 32'd0);
    add_row(mk(sbic_pkg::OP_IMUL, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_SIPUSH, 8'h7F, 8'hFF), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_IMUL, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_ISTORE, 8'hFF, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_IINC, 8'hFF, 8'h80), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_IINC, 8'h00, 8'h7F), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_ICONST5, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_ICONST0, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_ISUB, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_ILOAD0, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_BIPUSH, 8'hFF, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_IDIV, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_DUP, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_IADD, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_DUP, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_IFCMPGE, 8'hFF, 8'hF0), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_ILOAD3, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_ISTORE3, 8'h00, 8'h00), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_GOTO, 8'h7F, 8'hFF), 0, 0, 0, 0);
    add_row(mk(sbic_pkg::OP_GOTO, 8'h80, 8'h01), 0, 0, 0, 0);
    foreach (directed[i]) begin
      send_instr(directed[i].ins);
      if (directed[i].known) begin
        got = pending_results[$];
        if (got.next_pc !== directed[i].res.next_pc) begin
          $error("row %0d next_pc: expected %h, actual %h", i,
                 directed[i].res.next_pc, got.next_pc);
          errors++;
        end
        if (got.status !== directed[i].res.status) begin
          $error("row %0d status: expected %0d, actual %0d", i,
                 directed[i].res.status, got.status);
          errors++;
        end
        if (got.value !== directed[i].res.value) begin
          $error("row %0d value: expected %h, actual %h", i,
                 directed[i].res.value, got.value);
          errors++;
        end
      end
    end

    // Long well-formed program; a quiet stretch, then a receiver hold-off.
    for (int n = 0; n < 1150; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 600) hold_sink = 1'b1;
      if (n == 640) hold_sink = 1'b0;
      ins = random_running_instr();
      send_instr(ins);
      if (halt_q != sbic_pkg::ST_RUN) break;
    end
    calm = 1'b0;
    // Stack fault on an emptied stack, then the halted status must repeat.
    if (halt_q == sbic_pkg::ST_RUN) begin
      while (depth_q > 0) send_instr(mk(sbic_pkg::OP_ISTORE0, 8'h00, 8'h00));
      send_instr(mk(sbic_pkg::OP_IADD, 8'h00, 8'h00));
    end
    repeat (3) send_instr(mk(sbic_pkg::OP_RETURN, 8'hAA, 8'h55));
    in_if.valid <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Ran %0d instruction beats, %0d results checked, %0d halted results.",
             beats_sent, beats_seen, halts_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("stack_bytecode_integer_core regression: pass");
    end else begin
      $display("stack_bytecode_integer_core regression: fail");
    end
    $finish;
  end

  // Receiver: random stalls, plus a long counted hold-off.
  initial begin
    int hold_cnt;
    out_if.ready = 1'b0;
    hold_cnt = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink && hold_cnt < 400) begin
        hold_cnt++;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    sbic_pkg::result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      beats_seen++;
      if (pending_results.size() == 0) begin
        $error("result beat with no expected result");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.status != sbic_pkg::ST_RUN) halts_seen++;
        if (out_if.data.next_pc !== want.next_pc) begin
          $error("next_pc: expected %h, actual %h", want.next_pc, out_if.data.next_pc);
          errors++;
        end
        if (out_if.data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_if.data.status);
          errors++;
        end
        if (out_if.data.value !== want.value) begin
          $error("value: expected %h, actual %h", want.value, out_if.data.value);
          errors++;
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("stack_bytecode_integer_core regression: fail");
    $finish;
  end

endmodule
